// File: rtl/swb_pkg.sv
// Shared types and constants for the timed store write buffer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package swb_pkg;

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int WORD_W     = ADDR_W - 2;
  localparam int LANE_W     = 4;
  localparam int DELAY_W    = 4;
  localparam int FILL_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_TICK    = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  // Register select bit (paddr[2])
  localparam logic REG_FIRST_WRITE = 1'b0;
  localparam logic REG_SAME_PAGE   = 1'b1;

  localparam logic [DELAY_W-1:0] FIRST_WRITE_RST = 4'd4;
  localparam logic [DELAY_W-1:0] SAME_PAGE_RST   = 4'd2;

  typedef struct packed {
    logic empty;      // no entry pending
    logic last;       // exactly one entry pending
    logic full;       // no free entry
    logic page_same;  // head and next entry share a page
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/store_write_buffer_timed_core.sv
// Timed store write buffer: top level with input register, result register and config.
// Each accepted word passes through the input register, then the result register.
// Throughput: one word per cycle; a result waiting on out_stall stalls the input register.
// Reset (rst_n low, synchronous): queue empty, times zero, delays 4 and 2, no words valid.
// Depends on swb_pkg, swb_entry_queue and swb_drain_ctrl.
`default_nettype none

module store_write_buffer_timed_core #(
  parameter int FIFO_DEPTH = 4,
  parameter int PAGE_SHIFT = 10,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_operation,
  input  wire logic [swb_pkg::ADDR_W-1:0]           in_cpu_address,
  input  wire logic [swb_pkg::ADDR_W-1:0]           in_ram_offset,
  input  wire logic [swb_pkg::DATA_W-1:0]           in_store_data,
  input  wire logic [swb_pkg::LANE_W-1:0]           in_lane_mask,
  input  wire logic                                 in_bus_grant,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_ram_write_valid,
  output logic [swb_pkg::ADDR_W-1:0]                out_ram_write_offset,
  output logic [swb_pkg::DATA_W-1:0]                out_ram_write_data,
  output logic [swb_pkg::LANE_W-1:0]                out_ram_write_lanes,
  output logic                                      out_accepted,
  output logic                                      out_conflict,
  output logic [swb_pkg::FILL_W-1:0]                out_fill_level,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [swb_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [swb_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [swb_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                      pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers: 0 first write delay, 1 same page delay.
  // ---------------------------------------------------------------------------
  logic [swb_pkg::DELAY_W-1:0] first_delay_r;
  logic [swb_pkg::DELAY_W-1:0] same_delay_r;
  logic                        cfg_write;
  logic [swb_pkg::DELAY_W-1:0] cfg_read_val;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r <= swb_pkg::FIRST_WRITE_RST;
      same_delay_r  <= swb_pkg::SAME_PAGE_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        swb_pkg::REG_FIRST_WRITE: first_delay_r <= pwdata[swb_pkg::DELAY_W-1:0];
        swb_pkg::REG_SAME_PAGE:   same_delay_r  <= pwdata[swb_pkg::DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_read_val = (paddr[2] == swb_pkg::REG_SAME_PAGE) ? same_delay_r : first_delay_r;
  assign prdata       = {{(swb_pkg::CFG_DATA_W - swb_pkg::DELAY_W){1'b0}}, cfg_read_val};

  // ---------------------------------------------------------------------------
  // Input register. Hold the word while the result register cannot take a new
  // result; otherwise advance every cycle.
  // ---------------------------------------------------------------------------
  logic                        s1_valid_r;
  swb_pkg::op_t                s1_op_r;
  logic [swb_pkg::ADDR_W-1:0]  s1_address_r;
  logic [swb_pkg::ADDR_W-1:0]  s1_offset_r;
  logic [swb_pkg::DATA_W-1:0]  s1_data_r;
  logic [swb_pkg::LANE_W-1:0]  s1_lanes_r;
  logic                        s1_grant_r;
  logic                        advance;
  logic                        step;

  logic                        out_valid_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign step     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r      <= swb_pkg::op_t'(in_operation);
      s1_address_r <= in_cpu_address;
      s1_offset_r  <= in_ram_offset;
      s1_data_r    <= in_store_data;
      s1_lanes_r   <= in_lane_mask;
      s1_grant_r   <= in_bus_grant;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry queue and drain timing. Enqueue and retire never share a step since
  // retire happens only on a tick.
  // ---------------------------------------------------------------------------
  swb_pkg::q_status_t          qs;
  logic                        push;
  logic                        retire;
  logic                        check_hit;
  logic [swb_pkg::ADDR_W-1:0]  head_offset;
  logic [swb_pkg::DATA_W-1:0]  head_data;
  logic [swb_pkg::LANE_W-1:0]  head_lanes;
  logic [swb_pkg::FILL_W-1:0]  fill_nxt;

  assign push = step && (s1_op_r == swb_pkg::OP_ENQUEUE) && !qs.full;

  swb_entry_queue #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .pop          (retire),
    .push_address (s1_address_r),
    .push_offset  (s1_offset_r),
    .push_data    (s1_data_r),
    .push_lanes   (s1_lanes_r),
    .check_word   (s1_offset_r[swb_pkg::ADDR_W-1:2]),
    .check_lanes  (s1_lanes_r),
    .check_hit    (check_hit),
    .head_offset  (head_offset),
    .head_data    (head_data),
    .head_lanes   (head_lanes),
    .status       (qs),
    .fill_nxt     (fill_nxt)
  );

  swb_drain_ctrl #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .op          (s1_op_r),
    .grant       (s1_grant_r),
    .qs          (qs),
    .first_delay (first_delay_r),
    .same_delay  (same_delay_r),
    .retire      (retire)
  );

  // ---------------------------------------------------------------------------
  // Result register. Load on each step; zero the fields that do not apply.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ram_write_valid  <= retire;
      out_ram_write_offset <= retire ? head_offset : '0;
      out_ram_write_data   <= retire ? head_data : '0;
      out_ram_write_lanes  <= retire ? head_lanes : '0;
      out_accepted         <= push;
      out_conflict         <= (s1_op_r == swb_pkg::OP_CHECK) && check_hit;
      out_fill_level       <= fill_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_retire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    retire |-> (step && (s1_op_r == swb_pkg::OP_TICK) && !qs.empty))
    else $error("retire outside a tick or on an empty queue");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    qs.full |-> !push)
    else $error("push into a full queue");

  a_retire_reported: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> (out_valid_r && out_ram_write_valid))
    else $error("retired entry not presented as a result");

  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !step)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/swb_entry_queue.sv
// Shift-style entry queue: head always in slot 0, lane-positioned data,
// parallel conflict compare. Depends on swb_pkg.
`default_nettype none

module swb_entry_queue #(
  parameter int FIFO_DEPTH = 4,
  parameter int PAGE_SHIFT = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic                          pop,
  input  wire logic [swb_pkg::ADDR_W-1:0]    push_address,
  input  wire logic [swb_pkg::ADDR_W-1:0]    push_offset,
  input  wire logic [swb_pkg::DATA_W-1:0]    push_data,
  input  wire logic [swb_pkg::LANE_W-1:0]    push_lanes,
  input  wire logic [swb_pkg::WORD_W-1:0]    check_word,
  input  wire logic [swb_pkg::LANE_W-1:0]    check_lanes,
  output logic                               check_hit,
  output logic [swb_pkg::ADDR_W-1:0]         head_offset,
  output logic [swb_pkg::DATA_W-1:0]         head_data,
  output logic [swb_pkg::LANE_W-1:0]         head_lanes,
  output swb_pkg::q_status_t                 status,
  output logic [swb_pkg::FILL_W-1:0]         fill_nxt
);

  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W  = $clog2(FIFO_DEPTH);
  localparam int PAGE_W = swb_pkg::ADDR_W - PAGE_SHIFT;

  logic [swb_pkg::WORD_W-1:0] entry_word_r  [FIFO_DEPTH];
  logic [swb_pkg::DATA_W-1:0] entry_data_r  [FIFO_DEPTH];
  logic [swb_pkg::LANE_W-1:0] entry_lanes_r [FIFO_DEPTH];
  logic [PAGE_W-1:0]          entry_page_r  [FIFO_DEPTH];

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W+swb_pkg::FILL_W-1:0] count_ext;
  logic [IDX_W-1:0]        tail_idx;
  logic [swb_pkg::DATA_W-1:0] shifted_data;

  assign tail_idx     = count_r[IDX_W-1:0];
  assign shifted_data = push_data << {push_address[1:0], 3'b000};

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext = {{swb_pkg::FILL_W{1'b0}}, count_nxt};
  assign fill_nxt  = count_ext[swb_pkg::FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Advance every slot toward the head on pop; write the tail on push.
  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (pop && (i < FIFO_DEPTH - 1)) begin
        entry_word_r[i]  <= entry_word_r[i+1];
        entry_data_r[i]  <= entry_data_r[i+1];
        entry_lanes_r[i] <= entry_lanes_r[i+1];
        entry_page_r[i]  <= entry_page_r[i+1];
      end else if (push && (tail_idx == IDX_W'(i))) begin
        entry_word_r[i]  <= push_offset[swb_pkg::ADDR_W-1:2];
        entry_data_r[i]  <= shifted_data;
        entry_lanes_r[i] <= push_lanes;
        entry_page_r[i]  <= push_address[swb_pkg::ADDR_W-1:PAGE_SHIFT];
      end
    end
  end

  always_comb begin
    check_hit = 1'b0;
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if ((CNT_W'(i) < count_r) && (entry_word_r[i] == check_word) &&
          ((entry_lanes_r[i] & check_lanes) != '0)) begin
        check_hit = 1'b1;
      end
    end
  end

  assign head_offset = {entry_word_r[0], 2'b00};
  assign head_data   = entry_data_r[0];
  assign head_lanes  = entry_lanes_r[0];

  assign status.empty     = (count_r == '0);
  assign status.last      = (count_r == CNT_W'(1));
  assign status.full      = (count_r == CNT_W'(FIFO_DEPTH));
  assign status.page_same = (entry_page_r[0] == entry_page_r[1]);

endmodule

`default_nettype wire

// File: rtl/swb_drain_ctrl.sv
// Drain timing: cycle counter, bus request, completion time and retire decision.
// Depends on swb_pkg.
`default_nettype none

module swb_drain_ctrl #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire swb_pkg::op_t                 op,
  input  wire logic                         grant,
  input  wire swb_pkg::q_status_t           qs,
  input  wire logic [swb_pkg::DELAY_W-1:0]  first_delay,
  input  wire logic [swb_pkg::DELAY_W-1:0]  same_delay,
  output logic                              retire
);

  logic [TIME_WIDTH-1:0]       cyc_r, cyc_nxt;
  logic [TIME_WIDTH-1:0]       ready_r, ready_nxt;
  logic [TIME_WIDTH-1:0]       comp_r, comp_nxt;
  logic [swb_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic                        sched_r, sched_nxt;

  logic [TIME_WIDTH-1:0]       cyc_inc;
  logic [TIME_WIDTH-1:0]       comp_try;
  logic                        sched_try;
  logic [swb_pkg::DELAY_W-1:0] next_delay;

  assign cyc_inc    = cyc_r + TIME_WIDTH'(1);
  assign next_delay = qs.page_same ? same_delay : first_delay;

  always_comb begin
    cyc_nxt   = cyc_r;
    ready_nxt = ready_r;
    comp_nxt  = comp_r;
    delay_nxt = delay_r;
    sched_nxt = sched_r;
    comp_try  = comp_r;
    sched_try = sched_r;
    retire    = 1'b0;
    if (step) begin
      unique case (op)
        swb_pkg::OP_ENQUEUE: begin
          // First entry: request the bus right away
          if (qs.empty) begin
            ready_nxt = cyc_r;
            delay_nxt = first_delay;
            if (grant) begin
              comp_nxt  = cyc_r + TIME_WIDTH'(first_delay);
              sched_nxt = 1'b1;
            end else begin
              comp_nxt  = '0;
              sched_nxt = 1'b0;
            end
          end
        end
        swb_pkg::OP_TICK: begin
          cyc_nxt = cyc_inc;
          if (!qs.empty && !sched_r) begin
            if (grant) begin
              comp_try  = ready_r + TIME_WIDTH'(delay_r);
              sched_try = 1'b1;
            end else begin
              ready_nxt = cyc_inc;
            end
          end
          comp_nxt  = comp_try;
          sched_nxt = sched_try;
          if (!qs.empty && sched_try && (comp_try <= cyc_inc)) begin
            retire = 1'b1;
            if (qs.last) begin
              ready_nxt = '0;
              delay_nxt = first_delay;
              comp_nxt  = '0;
              sched_nxt = 1'b0;
            end else begin
              delay_nxt = next_delay;
              if (grant) begin
                ready_nxt = comp_try;
                comp_nxt  = comp_try + TIME_WIDTH'(next_delay);
                sched_nxt = 1'b1;
              end else begin
                ready_nxt = cyc_inc;
                comp_nxt  = '0;
                sched_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r   <= '0;
      ready_r <= '0;
      comp_r  <= '0;
      delay_r <= swb_pkg::FIRST_WRITE_RST;
      sched_r <= 1'b0;
    end else begin
      cyc_r   <= cyc_nxt;
      ready_r <= ready_nxt;
      comp_r  <= comp_nxt;
      delay_r <= delay_nxt;
      sched_r <= sched_nxt;
    end
  end

endmodule

`default_nettype wire

// File: tb/swb_checker.sv
// Scoreboard for the timed store write buffer: tracks register writes, predicts one
// result word per accepted input word and compares it field by field.
// Depends on swb_pkg for the operation codes, register select and reset delays.
`timescale 1ns / 1ps

module swb_checker #(
  parameter int FIFO_DEPTH = 4,
  parameter int PAGE_SHIFT = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_cpu_address,
  input  logic [31:0] in_ram_offset,
  input  logic [31:0] in_store_data,
  input  logic [3:0]  in_lane_mask,
  input  logic        in_bus_grant,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ram_write_valid,
  input  logic [31:0] out_ram_write_offset,
  input  logic [31:0] out_ram_write_data,
  input  logic [3:0]  out_ram_write_lanes,
  input  logic        out_accepted,
  input  logic        out_conflict,
  input  logic [2:0]  out_fill_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          outstanding,
  output int          drain_count,
  output int          conflict_count
);

  typedef struct {
    logic        wr_valid;
    logic [31:0] wr_offset;
    logic [31:0] wr_data;
    logic [3:0]  wr_lanes;
    logic        accepted;
    logic        conflict;
    logic [2:0]  fill;
  } buffer_result_t;

  buffer_result_t result_q[$];

  // shadow of the buffer
  logic [31:0] q_addr  [FIFO_DEPTH];
  logic [31:0] q_offs  [FIFO_DEPTH];
  logic [31:0] q_data  [FIFO_DEPTH];
  logic [3:0]  q_lanes [FIFO_DEPTH];
  int unsigned head;
  int unsigned fill;
  logic [31:0] cycle_now;
  logic [31:0] ready_at;
  logic [31:0] done_at;
  logic [3:0]  drain_cycles;
  logic        drain_armed;
  logic [3:0]  cfg_first;
  logic [3:0]  cfg_same;

  int mismatches;
  int drains;
  int conflicts;

  assign mismatch_count = mismatches;
  assign drain_count    = drains;
  assign conflict_count = conflicts;

  // Ask for the bus unless a drain is already armed or nothing is pending.
  task automatic request_bus(input logic grant);
    if (fill != 0 && !drain_armed) begin
      if (!grant) begin
        ready_at = cycle_now;
      end else begin
        done_at     = ready_at + 32'(drain_cycles);
        drain_armed = 1'b1;
      end
    end
  endtask

  task automatic predict_result(input logic [1:0] op, input logic [31:0] addr, offs, data,
                                input logic [3:0] lanes, input logic grant,
                                output buffer_result_t r);
    int unsigned tail;
    int unsigned k;
    logic [31:0] finish_at;
    logic [31:0] old_addr;
    r = '{default: '0};
    case (op)
      swb_pkg::OP_ENQUEUE: begin
        if (fill < FIFO_DEPTH) begin
          tail          = (head + fill) % FIFO_DEPTH;
          q_addr[tail]  = addr & ~32'd3;
          q_offs[tail]  = offs & ~32'd3;
          q_data[tail]  = data << {addr[1:0], 3'b000};
          q_lanes[tail] = lanes;
          fill++;
          if (fill == 1) begin
            ready_at     = cycle_now;
            drain_cycles = cfg_first;
            drain_armed  = 1'b0;
            done_at      = '0;
            request_bus(grant);
          end
          r.accepted = 1'b1;
        end
      end
      swb_pkg::OP_TICK: begin
        cycle_now = cycle_now + 32'd1;
        request_bus(grant);
        if (fill != 0 && drain_armed && done_at <= cycle_now) begin
          finish_at   = done_at;
          old_addr    = q_addr[head];
          r.wr_valid  = 1'b1;
          r.wr_offset = q_offs[head];
          r.wr_data   = q_data[head];
          r.wr_lanes  = q_lanes[head];
          head        = (head + 1) % FIFO_DEPTH;
          fill--;
          drain_armed = 1'b0;
          done_at     = '0;
          if (fill == 0) begin
            head         = 0;
            ready_at     = '0;
            drain_cycles = cfg_first;
          end else begin
            ready_at     = finish_at;
            drain_cycles = ((old_addr >> PAGE_SHIFT) == (q_addr[head] >> PAGE_SHIFT)) ?
                           cfg_same : cfg_first;
            request_bus(grant);
          end
        end
      end
      swb_pkg::OP_CHECK: begin
        for (int i = 0; i < fill; i++) begin
          k = (head + i) % FIFO_DEPTH;
          if (q_offs[k] == (offs & ~32'd3) && (q_lanes[k] & lanes) != 4'd0)
            r.conflict = 1'b1;
        end
      end
      default: ;
    endcase
    r.fill = fill[2:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    buffer_result_t want;
    if (!rst_n) begin
      result_q.delete();
      head         = 0;
      fill         = 0;
      cycle_now    = '0;
      ready_at     = '0;
      done_at      = '0;
      drain_armed  = 1'b0;
      cfg_first    = swb_pkg::FIRST_WRITE_RST;
      cfg_same     = swb_pkg::SAME_PAGE_RST;
      drain_cycles = swb_pkg::FIRST_WRITE_RST;
      mismatches   = 0;
      drains       = 0;
      conflicts    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == swb_pkg::REG_SAME_PAGE) cfg_same = pwdata[3:0];
        else cfg_first = pwdata[3:0];
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("ram_write_valid", 32'(want.wr_valid), 32'(out_ram_write_valid));
          check_field("ram_write_offset", want.wr_offset, out_ram_write_offset);
          check_field("ram_write_data", want.wr_data, out_ram_write_data);
          check_field("ram_write_lanes", 32'(want.wr_lanes), 32'(out_ram_write_lanes));
          check_field("accepted", 32'(want.accepted), 32'(out_accepted));
          check_field("conflict", 32'(want.conflict), 32'(out_conflict));
          check_field("fill_level", 32'(want.fill), 32'(out_fill_level));
        end
      end
      if (in_valid && !in_stall) begin
        predict_result(in_operation, in_cpu_address, in_ram_offset, in_store_data,
                       in_lane_mask, in_bus_grant, want);
        if (want.wr_valid) drains++;
        if (want.conflict) conflicts++;
        result_q.push_back(want);
      end
    end
    outstanding <= result_q.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the store write buffer testbench: clock, reset, stimulus and verdict.
// Instantiates store_write_buffer_timed_core and swb_checker; uses swb_pkg codes.
`timescale 1ns / 1ps

module testbench;

  localparam int FIFO_DEPTH  = 4;
  localparam int PAGE_SHIFT  = 10;
  localparam int TIME_WIDTH  = 32;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 100;

  // The fourth operation code is not decoded by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Byte addresses of the two delay registers.
  localparam logic [2:0] ADDR_FIRST_WRITE = {swb_pkg::REG_FIRST_WRITE, 2'b00};
  localparam logic [2:0] ADDR_SAME_PAGE   = {swb_pkg::REG_SAME_PAGE, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [31:0] in_cpu_address;
  logic [31:0] in_ram_offset;
  logic [31:0] in_store_data;
  logic [3:0]  in_lane_mask;
  logic        in_bus_grant;
  logic        out_valid;
  logic        out_stall;
  logic        out_ram_write_valid;
  logic [31:0] out_ram_write_offset;
  logic [31:0] out_ram_write_data;
  logic [3:0]  out_ram_write_lanes;
  logic        out_accepted;
  logic        out_conflict;
  logic [2:0]  out_fill_level;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int outstanding;
  int drain_count;
  int conflict_count;

  // Shared between the sender and the result-side process.
  logic quiet;     // no idling on either side
  logic hold_req;  // ask the result side for one long hold-off

  int          words_sent;
  int          settings_used;
  logic [21:0] page_pool [4];
  logic [31:0] recent_offs [8];
  int          recent_slot;
  int          first_set [PHASES] = '{1, 15, 0, 15, 1, 0};
  int          same_set  [PHASES] = '{1, 15, 0, 1, 15, 0};

  store_write_buffer_timed_core #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .PAGE_SHIFT(PAGE_SHIFT),
    .TIME_WIDTH(TIME_WIDTH)
  ) dut (.*);

  swb_checker #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: stall at random, once hold off for a long stretch so that the
  // block fills up and pushes back on its input.
  always @(posedge clk) begin
    int  hold_left;
    bit  hold_used;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_used = 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_used) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_used = 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] addr, offs, data,
                           input logic [3:0] lanes, input logic grant);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_cpu_address <= addr;
    in_ram_offset  <= offs;
    in_store_data  <= data;
    in_lane_mask   <= lanes;
    in_bus_grant   <= grant;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Tick with random payload; only the grant matters.
  task automatic send_tick(input logic grant);
    send_word(swb_pkg::OP_TICK, $urandom, $urandom, $urandom, 4'($urandom), grant);
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Setup cycle, then access cycle; the register takes the value when pready is high.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ticks and stores into four pages, plus checks against recently stored words,
  // so that same-page drains and real conflicts occur; the rest is plain noise.
  task automatic send_random_word();
    int          pick;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] offs;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = swb_pkg::OP_ENQUEUE;
    else if (pick < 80) op = swb_pkg::OP_TICK;
    else if (pick < 97) op = swb_pkg::OP_CHECK;
    else op = OP_UNUSED;
    if ($urandom_range(0, 9) < 7) addr = {page_pool[$urandom_range(0, 3)], 10'($urandom)};
    else addr = $urandom;
    if (op == swb_pkg::OP_CHECK && $urandom_range(0, 9) < 6)
      offs = {recent_offs[$urandom_range(0, 7)][31:2], 2'($urandom)};
    else
      offs = $urandom;
    send_word(op, addr, offs, $urandom, 4'($urandom), $urandom_range(0, 3) != 0);
    if (op == swb_pkg::OP_ENQUEUE) begin
      recent_offs[recent_slot] = offs;
      recent_slot = (recent_slot + 1) % 8;
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = swb_pkg::OP_ENQUEUE;
    in_cpu_address = '0;
    in_ram_offset  = '0;
    in_store_data  = '0;
    in_lane_mask   = '0;
    in_bus_grant   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    words_sent     = 0;
    settings_used  = 1;
    recent_slot    = 0;
    foreach (page_pool[i]) page_pool[i] = 22'($urandom);
    foreach (recent_offs[i]) recent_offs[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset delays (4 and 2).
    // Check and unused code on an empty buffer.
    send_word(swb_pkg::OP_CHECK, '0, '0, '0, 4'hF, 1'b0);
    send_word(OP_UNUSED, '1, '1, '1, 4'hF, 1'b1);
    // Fill the buffer with the bus refused: top byte shift, page change, same page.
    send_word(swb_pkg::OP_ENQUEUE, 32'h0000_0003, 32'h0000_0010, 32'hFFFF_FFFF, 4'h8, 1'b0);
    send_word(swb_pkg::OP_ENQUEUE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_A5A5, 4'hC, 1'b0);
    send_word(swb_pkg::OP_ENQUEUE, 32'hFFFF_FC01, 32'h0000_0013, 32'h0000_0000, 4'h1, 1'b1);
    send_word(swb_pkg::OP_ENQUEUE, 32'h8000_0000, 32'h0000_0020, 32'h1234_5678, 4'hF, 1'b0);
    // Full buffer: this store must be refused.
    send_word(swb_pkg::OP_ENQUEUE, 32'h0000_0400, 32'h0000_0030, 32'hDEAD_BEEF, 4'h3, 1'b1);
    // One hit on an overlapping lane, one miss on the same word.
    send_word(swb_pkg::OP_CHECK, 32'h0, 32'h0000_0011, 32'h0, 4'h8, 1'b0);
    send_word(swb_pkg::OP_CHECK, 32'h0, 32'h0000_0010, 32'h0, 4'h6, 1'b0);
    // Bus refused twice, then granted until the buffer drains.
    repeat (2) send_tick(1'b0);
    repeat (14) send_tick(1'b1);
    // Store into an empty buffer with the grant present: drain is armed at once.
    send_word(swb_pkg::OP_ENQUEUE, 32'h0000_0400, 32'h0000_0040, 32'h0000_00FF, 4'h1, 1'b1);
    repeat (4) send_tick(1'b1);

    // Random phases, each at its own pair of delays, extremes included.
    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      repeat (4) @(posedge clk);
      if (p == PHASES - 1) begin
        first_set[p] = $urandom_range(0, 15);
        same_set[p]  = $urandom_range(0, 15);
      end
      write_reg(ADDR_FIRST_WRITE, 32'(first_set[p]));
      write_reg(ADDR_SAME_PAGE, 32'(same_set[p]));
      settings_used++;
      // Phase 1 runs without any idling on either side.
      quiet <= (p == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Long result hold-off while words keep coming.
        if (p == 3 && n == 20) hold_req <= 1'b1;
        // Let the block run dry in the middle of a phase.
        if (p == 4 && n == 50) wait_for_results();
        if (p != 1 && $urandom_range(0, 99) < 20) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        send_random_word();
      end
    end

    // Drain, then let a few more cycles pass for any stray result word.
    wait_for_results();
    repeat (4) @(posedge clk);

    if (outstanding != 0) $error("%0d expected result words never arrived", outstanding);
    $display("Summary: %0d words sent under %0d delay settings, %0d RAM writes, %0d conflicts.",
             words_sent, settings_used, drain_count, conflict_count);
    $display("Summary: full buffer, refused bus, page changes, zero delays and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: store_write_buffer_timed_core.f
rtl/swb_pkg.sv
rtl/swb_entry_queue.sv
rtl/swb_drain_ctrl.sv
rtl/store_write_buffer_timed_core.sv
tb/swb_checker.sv
tb/testbench.sv
